// ----- rtl/kvlt_pkg.sv -----
package kvlt_pkg;

  typedef enum logic [2:0] {
    ST_PRE_KEY  = 3'd0,
    ST_KEY      = 3'd1,
    ST_PRE_VAL  = 3'd2,
    ST_VAL      = 3'd3,
    ST_POST_VAL = 3'd4,
    ST_ERROR    = 3'd5
  } parse_state_t;

  typedef enum logic [2:0] {
    EV_KEY_CHAR   = 3'd0,
    EV_VAL_CHAR   = 3'd1,
    EV_DONE       = 3'd2,
    EV_INCOMPLETE = 3'd3,
    EV_TRAILING   = 3'd4,
    EV_KEY_OVF    = 3'd5,
    EV_VAL_OVF    = 3'd6
  } event_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       nl;
    logic       ws;
  } token_t;

  typedef struct packed {
    event_t     ev;
    logic [7:0] ch;
    logic [7:0] key_length;
    logic [7:0] value_length;
  } result_t;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_LIMIT   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_VALUE_LIMIT = 2'd1;

  localparam logic [7:0] LIMIT_RESET = 8'hFF;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SEMI  = 8'h3B;

endpackage

// ----- rtl/key_value_line_tokenizer.sv -----
// An accepted byte is written into the token queue, then parsed from the queue head into
// the output register if it yields a result; it waits in the queue while the output side stalls.
// Throughput: one byte per cycle while the token queue is not full, set by the parser step in the back end.
// The token queue lets input keep flowing for QUEUE_DEPTH beats while the output stalls.
// Reset clears the parser state, comment flag, lengths, queue pointers and output valid flag,
// and sets both length limits to 255.
module key_value_line_tokenizer #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [7:0]                       s_axis_tdata,  // [7:0] byte_in
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [23:0]                      m_axis_tdata,  // [7:0] char_out, [15:8] key_length,
                                                          // [23:16] value_length
  output logic [2:0]                       m_axis_tuser,  // [2:0] event_res
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [kvlt_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]                       cfg_data
);

  logic [7:0] key_limit;
  logic [7:0] value_limit;
  logic       in_accept;
  logic       q_full;
  logic       q_valid;
  logic       q_pop;
  kvlt_pkg::token_t  front_tok;
  kvlt_pkg::token_t  back_tok;
  kvlt_pkg::result_t res;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !q_full;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_limit   <= kvlt_pkg::LIMIT_RESET;
      value_limit <= kvlt_pkg::LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == kvlt_pkg::REG_KEY_LIMIT) begin
        key_limit <= cfg_data;
      end
      if (cfg_index == kvlt_pkg::REG_VALUE_LIMIT) begin
        value_limit <= cfg_data;
      end
    end
  end

  kvlt_front u_front (
    .clk     (clk),
    .rst     (rst),
    .byte_in (s_axis_tdata),
    .accept  (in_accept),
    .tok     (front_tok)
  );

  kvlt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_accept),
    .push_data (front_tok),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (back_tok)
  );

  kvlt_back u_back (
    .clk         (clk),
    .rst         (rst),
    .tok_valid   (q_valid),
    .tok         (back_tok),
    .pop         (q_pop),
    .key_limit   (key_limit),
    .value_limit (value_limit),
    .res_valid   (m_axis_tvalid),
    .res_ready   (m_axis_tready),
    .res         (res)
  );

  assign m_axis_tuser = res.ev;
  assign m_axis_tdata = {res.value_length, res.key_length, res.ch};

`ifndef SYNTHESIS
  a_char_only_on_char_events: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser != kvlt_pkg::EV_KEY_CHAR)
      && (m_axis_tuser != kvlt_pkg::EV_VAL_CHAR)) |-> (m_axis_tdata[7:0] == 8'd0))
    else $error("non-character event carries a character");

  a_lengths_only_on_done: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser != kvlt_pkg::EV_DONE)) |-> (m_axis_tdata[23:8] == 16'd0))
    else $error("lengths present on an event other than done");

  a_done_has_lengths: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser == kvlt_pkg::EV_DONE))
      |-> ((m_axis_tdata[15:8] != 8'd0) && (m_axis_tdata[23:16] != 8'd0)))
    else $error("done event with an empty key or value");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("parser took a token from an empty queue");
`endif

endmodule

// ----- rtl/kvlt_front.sv -----
module kvlt_front (
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        byte_in,
  input  logic              accept,
  output kvlt_pkg::token_t  tok
);

  logic       comment_flag;
  logic       comment_flag_next;
  logic [7:0] mapped;
  logic [7:0] ch;
  logic       commenting;

  always_comb begin
    mapped = (byte_in == kvlt_pkg::CH_NUL) ? kvlt_pkg::CH_NL : byte_in;
    commenting = comment_flag || (mapped == kvlt_pkg::CH_SEMI);
    ch = (commenting && (mapped != kvlt_pkg::CH_NL)) ? kvlt_pkg::CH_SPACE : mapped;
    comment_flag_next = commenting && (mapped != kvlt_pkg::CH_NL);
    tok.ch = ch;
    tok.nl = (ch == kvlt_pkg::CH_NL);
    tok.ws = (ch == kvlt_pkg::CH_SPACE) || ((ch >= kvlt_pkg::CH_TAB) && (ch <= kvlt_pkg::CH_CR));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      comment_flag <= 1'b0;
    end else if (accept) begin
      comment_flag <= comment_flag_next;
    end
  end

endmodule

// ----- rtl/kvlt_queue.sv -----
module kvlt_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  kvlt_pkg::token_t  push_data,
  output logic              full,
  input  logic              pop,
  output logic              valid,
  output kvlt_pkg::token_t  pop_data
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  kvlt_pkg::token_t mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full     = (count == FULL_COUNT);
  assign valid    = (count != '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/kvlt_back.sv -----
module kvlt_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              tok_valid,
  input  kvlt_pkg::token_t  tok,
  output logic              pop,
  input  logic [7:0]        key_limit,
  input  logic [7:0]        value_limit,
  output logic              res_valid,
  input  logic              res_ready,
  output kvlt_pkg::result_t res
);

  kvlt_pkg::parse_state_t state;
  kvlt_pkg::parse_state_t state_next;
  logic [7:0] key_count;
  logic [7:0] key_count_next;
  logic [7:0] value_count;
  logic [7:0] value_count_next;
  logic              emit;
  kvlt_pkg::result_t res_next;

  assign pop = tok_valid && (!res_valid || res_ready);

  always_comb begin
    state_next = state;
    if (tok.nl) begin
      state_next = kvlt_pkg::ST_PRE_KEY;
    end else begin
      unique case (state)
        kvlt_pkg::ST_PRE_KEY:  if (!tok.ws) state_next = kvlt_pkg::ST_KEY;
        kvlt_pkg::ST_KEY:      if (tok.ws) state_next = kvlt_pkg::ST_PRE_VAL;
        kvlt_pkg::ST_PRE_VAL:  if (!tok.ws) state_next = kvlt_pkg::ST_VAL;
        kvlt_pkg::ST_VAL:      if (tok.ws) state_next = kvlt_pkg::ST_POST_VAL;
        kvlt_pkg::ST_POST_VAL: if (!tok.ws) state_next = kvlt_pkg::ST_ERROR;
        default:               state_next = state;
      endcase
    end
  end

  always_comb begin
    emit = 1'b0;
    res_next.ev = kvlt_pkg::EV_KEY_CHAR;
    res_next.ch = '0;
    res_next.key_length = '0;
    res_next.value_length = '0;
    key_count_next = tok.nl ? 8'd0 : key_count;
    value_count_next = tok.nl ? 8'd0 : value_count;
    unique case (state)
      kvlt_pkg::ST_PRE_KEY: begin
        if (!tok.nl && !tok.ws) begin
          emit = 1'b1;
          res_next.ev = kvlt_pkg::EV_KEY_CHAR;
          res_next.ch = tok.ch;
          key_count_next = 8'd1;
        end
      end
      kvlt_pkg::ST_KEY: begin
        if (tok.nl) begin
          emit = 1'b1;
          res_next.ev = kvlt_pkg::EV_INCOMPLETE;
        end else if (!tok.ws) begin
          emit = 1'b1;
          if (key_count < key_limit) begin
            res_next.ev = kvlt_pkg::EV_KEY_CHAR;
            res_next.ch = tok.ch;
            key_count_next = key_count + 8'd1;
          end else begin
            res_next.ev = kvlt_pkg::EV_KEY_OVF;
          end
        end
      end
      kvlt_pkg::ST_PRE_VAL: begin
        if (tok.nl) begin
          emit = 1'b1;
          res_next.ev = kvlt_pkg::EV_INCOMPLETE;
        end else if (!tok.ws) begin
          emit = 1'b1;
          res_next.ev = kvlt_pkg::EV_VAL_CHAR;
          res_next.ch = tok.ch;
          value_count_next = 8'd1;
        end
      end
      kvlt_pkg::ST_VAL: begin
        if (tok.nl) begin
          emit = 1'b1;
          res_next.ev = kvlt_pkg::EV_DONE;
          res_next.key_length = key_count;
          res_next.value_length = value_count;
        end else if (!tok.ws) begin
          emit = 1'b1;
          if (value_count < value_limit) begin
            res_next.ev = kvlt_pkg::EV_VAL_CHAR;
            res_next.ch = tok.ch;
            value_count_next = value_count + 8'd1;
          end else begin
            res_next.ev = kvlt_pkg::EV_VAL_OVF;
          end
        end
      end
      kvlt_pkg::ST_POST_VAL: begin
        if (tok.nl) begin
          emit = 1'b1;
          res_next.ev = kvlt_pkg::EV_DONE;
          res_next.key_length = key_count;
          res_next.value_length = value_count;
        end else if (!tok.ws) begin
          emit = 1'b1;
          res_next.ev = kvlt_pkg::EV_TRAILING;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= kvlt_pkg::ST_PRE_KEY;
      key_count   <= '0;
      value_count <= '0;
      res_valid   <= 1'b0;
    end else begin
      if (pop) begin
        state       <= state_next;
        key_count   <= key_count_next;
        value_count <= value_count_next;
        res_valid   <= emit;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      res <= res_next;
    end
  end

endmodule

// ----- tb/key_value_line_tokenizer_test.sv -----
`timescale 1ns / 100ps

module key_value_line_tokenizer_test;

  localparam int DRAIN_CYCLES      = 12;
  localparam int HOLD_CYCLES       = 200;
  localparam int QUIET_LIMIT       = 3000;
  localparam int RESULTS_PER_PHASE = 130;
  localparam int PHASES            = 8;

  localparam logic [kvlt_pkg::CFG_INDEX_W-1:0] REG_UNUSED_A = 2'd2;
  localparam logic [kvlt_pkg::CFG_INDEX_W-1:0] REG_UNUSED_B = 2'd3;

  class token_checker;
    kvlt_pkg::parse_state_t state;
    bit                     comment_on;
    logic [7:0]             key_len;
    logic [7:0]             val_len;
    logic [7:0]             key_limit;
    logic [7:0]             value_limit;
    kvlt_pkg::result_t      expected_events[$];
    int                     errors;
    int                     produced;

    function new();
      state       = kvlt_pkg::ST_PRE_KEY;
      comment_on  = 1'b0;
      key_len     = '0;
      val_len     = '0;
      key_limit   = kvlt_pkg::LIMIT_RESET;
      value_limit = kvlt_pkg::LIMIT_RESET;
      errors      = 0;
      produced    = 0;
    endfunction

    function void set_reg(logic [kvlt_pkg::CFG_INDEX_W-1:0] idx, logic [7:0] data);
      if (idx == kvlt_pkg::REG_KEY_LIMIT) begin
        key_limit = data;
      end else if (idx == kvlt_pkg::REG_VALUE_LIMIT) begin
        value_limit = data;
      end
    endfunction

    function bit is_space(logic [7:0] c);
      return c == kvlt_pkg::CH_SPACE || (c >= kvlt_pkg::CH_TAB && c <= kvlt_pkg::CH_CR);
    endfunction

    function void end_line();
      state   = kvlt_pkg::ST_PRE_KEY;
      key_len = '0;
      val_len = '0;
    endfunction

    function void note_byte(logic [7:0] b);
      logic [7:0]        c;
      bit                nl;
      bit                fire;
      kvlt_pkg::result_t r;
      c = (b == kvlt_pkg::CH_NUL) ? kvlt_pkg::CH_NL : b;
      if (c == kvlt_pkg::CH_SEMI) comment_on = 1'b1;
      if (comment_on) begin
        if (c == kvlt_pkg::CH_NL) comment_on = 1'b0;
        else c = kvlt_pkg::CH_SPACE;
      end
      nl   = (c == kvlt_pkg::CH_NL);
      fire = 1'b0;
      r    = '{ev: kvlt_pkg::EV_KEY_CHAR, ch: 8'd0, key_length: 8'd0, value_length: 8'd0};
      case (state)
        kvlt_pkg::ST_PRE_KEY: begin
          if (nl) begin
            end_line();
          end else if (!is_space(c)) begin
            state   = kvlt_pkg::ST_KEY;
            key_len = 8'd1;
            fire    = 1'b1;
            r.ev    = kvlt_pkg::EV_KEY_CHAR;
            r.ch    = c;
          end
        end
        kvlt_pkg::ST_KEY: begin
          fire = 1'b1;
          if (nl) begin
            end_line();
            r.ev = kvlt_pkg::EV_INCOMPLETE;
          end else if (is_space(c)) begin
            state = kvlt_pkg::ST_PRE_VAL;
            fire  = 1'b0;
          end else if (key_len < key_limit) begin
            key_len++;
            r.ev = kvlt_pkg::EV_KEY_CHAR;
            r.ch = c;
          end else begin
            r.ev = kvlt_pkg::EV_KEY_OVF;
          end
        end
        kvlt_pkg::ST_PRE_VAL: begin
          if (nl) begin
            end_line();
            fire = 1'b1;
            r.ev = kvlt_pkg::EV_INCOMPLETE;
          end else if (!is_space(c)) begin
            state   = kvlt_pkg::ST_VAL;
            val_len = 8'd1;
            fire    = 1'b1;
            r.ev    = kvlt_pkg::EV_VAL_CHAR;
            r.ch    = c;
          end
        end
        kvlt_pkg::ST_VAL: begin
          fire = 1'b1;
          if (nl) begin
            r.ev           = kvlt_pkg::EV_DONE;
            r.key_length   = key_len;
            r.value_length = val_len;
            end_line();
          end else if (is_space(c)) begin
            state = kvlt_pkg::ST_POST_VAL;
            fire  = 1'b0;
          end else if (val_len < value_limit) begin
            val_len++;
            r.ev = kvlt_pkg::EV_VAL_CHAR;
            r.ch = c;
          end else begin
            r.ev = kvlt_pkg::EV_VAL_OVF;
          end
        end
        kvlt_pkg::ST_POST_VAL: begin
          if (nl) begin
            fire           = 1'b1;
            r.ev           = kvlt_pkg::EV_DONE;
            r.key_length   = key_len;
            r.value_length = val_len;
            end_line();
          end else if (!is_space(c)) begin
            state = kvlt_pkg::ST_ERROR;
            fire  = 1'b1;
            r.ev  = kvlt_pkg::EV_TRAILING;
          end
        end
        default: begin
          if (nl) end_line();
        end
      endcase
      if (fire) begin
        expected_events.push_back(r);
        produced++;
      end
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    function void check_event(kvlt_pkg::result_t got);
      kvlt_pkg::result_t want;
      if (expected_events.size() == 0) begin
        report($sformatf("unexpected beat: ev=%0d ch=%02h kl=%0d vl=%0d",
                         got.ev, got.ch, got.key_length, got.value_length));
        return;
      end
      want = expected_events.pop_front();
      if (got.ev !== want.ev || got.ch !== want.ch ||
          got.key_length !== want.key_length || got.value_length !== want.value_length) begin
        report($sformatf({"mismatch: expected ev=%0d ch=%02h kl=%0d vl=%0d,",
                          " got ev=%0d ch=%02h kl=%0d vl=%0d"},
                         want.ev, want.ch, want.key_length, want.value_length,
                         got.ev, got.ch, got.key_length, got.value_length));
      end
    endfunction

    function int pending();
      return expected_events.size();
    endfunction
  endclass

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             s_axis_tvalid;
  logic                             s_axis_tready;
  logic [7:0]                       s_axis_tdata;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready;
  logic [23:0]                      m_axis_tdata;
  logic [2:0]                       m_axis_tuser;
  logic                             cfg_valid;
  logic                             cfg_ready;
  logic [kvlt_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [7:0]                       cfg_data;

  token_checker      chk = new();
  kvlt_pkg::result_t seen;
  bit                hold_req = 1'b0;
  bit                tx_smooth = 1'b0;
  int                quiet_cycles = 0;

  key_value_line_tokenizer dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen.ev           = kvlt_pkg::event_t'(m_axis_tuser);
        seen.ch           = m_axis_tdata[7:0];
        seen.key_length   = m_axis_tdata[15:8];
        seen.value_length = m_axis_tdata[23:16];
        chk.check_event(seen);
      end
      if (s_axis_tvalid && s_axis_tready) chk.note_byte(s_axis_tdata);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] word_char();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(1, 255));
    end while ((c >= kvlt_pkg::CH_TAB && c <= kvlt_pkg::CH_CR) || c == kvlt_pkg::CH_SPACE ||
               c == kvlt_pkg::CH_SEMI);
    return c;
  endfunction

  function automatic logic [7:0] space_char();
    case ($urandom_range(0, 4))
      0: return kvlt_pkg::CH_TAB;
      1: return 8'h0B;
      2: return 8'h0C;
      3: return kvlt_pkg::CH_CR;
      default: return kvlt_pkg::CH_SPACE;
    endcase
  endfunction

  function automatic int pick_len();
    if ($urandom_range(0, 99) == 0) return $urandom_range(250, 262);
    return $urandom_range(1, 6);
  endfunction

  // receiver: stretches at full rate, random stalls, one long hold-off on request
  initial begin : rx_side
    int  stall_left;
    int  run_left;
    bit  smooth;
    stall_left = 0;
    run_left   = 0;
    smooth     = 1'b0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        m_axis_tready <= 1'b1;
      end else begin
        if (run_left == 0) begin
          run_left = $urandom_range(20, 200);
          smooth   = ($urandom_range(0, 3) == 0);
        end
        run_left--;
        if (smooth) begin
          m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
          stall_left--;
          m_axis_tready <= 1'b0;
        end else begin
          stall_left = rand_gap();
          if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
          end else begin
            m_axis_tready <= 1'b1;
          end
        end
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input int gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic put_byte(input logic [7:0] b);
    send_byte(b, tx_smooth ? 0 : rand_gap());
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  // hold cfg_valid high across back-to-back writes; caller drops it afterwards
  task automatic write_reg(input logic [kvlt_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    chk.set_reg(idx, data);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (chk.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_line();
    int         kind;
    int         klen;
    int         vlen;
    logic [7:0] eol;
    tx_smooth = ($urandom_range(0, 3) == 0);
    eol  = ($urandom_range(0, 4) == 0) ? kvlt_pkg::CH_NUL : kvlt_pkg::CH_NL;
    kind = $urandom_range(0, 99);
    klen = pick_len();
    vlen = pick_len();
    if (kind < 12) begin
      repeat ($urandom_range(1, 12)) put_byte(8'($urandom_range(0, 255)));
    end else begin
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) put_byte(space_char());
      repeat (klen) put_byte(word_char());
      if (kind >= 20) begin
        repeat ($urandom_range(1, 2)) put_byte(space_char());
        if (kind >= 26) repeat (vlen) put_byte(word_char());
        if (kind >= 26 && kind < 34) begin
          put_byte(space_char());
          repeat ($urandom_range(1, 3)) put_byte(word_char());
        end
        if ($urandom_range(0, 3) == 0) put_byte(space_char());
      end
      if ($urandom_range(0, 4) == 0) begin
        put_byte(kvlt_pkg::CH_SEMI);
        repeat ($urandom_range(0, 5)) put_byte(8'($urandom_range(1, 255)));
      end
    end
    put_byte(eol);
  endtask

  initial begin : stimulus
    logic [7:0] kl;
    logic [7:0] vl;
    int         target;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 8'd0;
    cfg_valid     <= 1'b0;
    cfg_index     <= kvlt_pkg::REG_KEY_LIMIT;
    cfg_data      <= 8'd0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_reg(REG_UNUSED_A, 8'd7);
    write_reg(REG_UNUSED_B, 8'd9);
    write_reg(kvlt_pkg::REG_KEY_LIMIT, 8'd3);
    write_reg(kvlt_pkg::REG_VALUE_LIMIT, 8'd1);
    cfg_valid <= 1'b0;

    send_text("abcd\t ef\n");
    send_byte(kvlt_pkg::CH_NUL, rand_gap());
    send_text("k");
    send_byte(kvlt_pkg::CH_NUL, rand_gap());
    send_byte(8'hFF, rand_gap());
    send_byte(8'h80, rand_gap());
    send_byte(8'h0B, rand_gap());
    send_byte(8'h7F, rand_gap());
    send_byte(8'h0C, rand_gap());
    send_byte(8'h01, rand_gap());
    send_byte(kvlt_pkg::CH_CR, rand_gap());
    send_text("x\n");
    send_text("k;c v\n");

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      case (p)
        0: begin kl = 8'd255; vl = 8'd255; end
        1: begin kl = 8'd1;   vl = 8'd1;   end
        2: begin kl = 8'd0;   vl = 8'd0;   end
        3: begin kl = 8'd2;   vl = 8'd6;   end
        4: begin kl = 8'd255; vl = 8'd1;   end
        5: begin kl = 8'd1;   vl = 8'd255; end
        6: begin kl = 8'($urandom_range(0, 8)); vl = 8'($urandom_range(0, 255)); end
        default: begin kl = 8'($urandom_range(0, 255)); vl = 8'($urandom_range(0, 8)); end
      endcase
      if ($urandom_range(0, 1)) begin
        write_reg(kvlt_pkg::REG_KEY_LIMIT, kl);
        write_reg(kvlt_pkg::REG_VALUE_LIMIT, vl);
      end else begin
        write_reg(kvlt_pkg::REG_VALUE_LIMIT, vl);
        write_reg(kvlt_pkg::REG_KEY_LIMIT, kl);
      end
      if (p == 5) write_reg(REG_UNUSED_B, 8'hFF);
      cfg_valid <= 1'b0;
      if (p == 3) hold_req = 1'b1;
      target = chk.produced + RESULTS_PER_PHASE;
      while (chk.produced < target) send_line();
    end

    wait_idle();
    if (chk.errors == 0 && chk.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
